// ----- rtl/core/esma_pkg.sv -----
package esma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_HALF    = 32;
    localparam int RING_DEPTH  = 64;
    localparam int CFG_W       = 6;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int CNT_W   = RING_AW + 1;
    localparam int SUM_W   = SAMPLE_BITS + RING_AW;
    localparam int HALF_W  = $clog2(MAX_HALF + 1);
    localparam int FLUSH_W = RING_AW;
    localparam int DIV_CW  = $clog2(SUM_W);

    function automatic logic [HALF_W-1:0] eff_half(input logic [CFG_W-1:0] v);
        logic [HALF_W-1:0] r;
        if (v == '0) begin
            r = HALF_W'(1);
        end else if (int'(v) > MAX_HALF) begin
            r = HALF_W'(MAX_HALF);
        end else begin
            r = HALF_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_sample(input logic [SAMPLE_BITS-1:0] v);
        return {{(SUM_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
    endfunction

endpackage

// ----- rtl/core/edge_shrinking_moving_average.sv -----
// Centered moving average with a window that shrinks at both ends of the
// stream. Each accepted item is pushed into a 64-entry sample ring; a result
// leaves once half_width samples beyond its position have arrived, and the
// item marked last flushes the remaining results (at most MAX_HALF of them),
// the final one flagged by m_final_res. The block works on one item at a time:
// S_IDLE takes an item and S_PUSH pushes it, after S_PRE_RD and S_PRE_SUB
// have dropped the oldest sample if the ring is full. Each result then passes
// S_CHECK, then S_DROP_RD and S_DROP_SUB for every old sample that leaves the
// window (usually one in the interior of the stream), S_DIV in the bit-serial
// divider over the 22-bit window sum, and S_OUT to load the output register,
// where a finished result waits while the next item is taken. The user must
// write half_width through the cfg port only while the block is idle; the
// block does not enforce this. 0 acts as 1, values above MAX_HALF as MAX_HALF.
module edge_shrinking_moving_average import esma_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_average,
    output logic                          m_final_res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_RD,
        S_PRE_SUB,
        S_PUSH,
        S_CHECK,
        S_DROP_RD,
        S_DROP_SUB,
        S_DIV,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [CFG_W-1:0]         half_width_reg;
    logic [HALF_W-1:0]        h_reg;
    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic                     last_reg;
    logic [RING_AW-1:0]       head_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         seen_reg;
    logic [CNT_W-1:0]         emit_reg;
    logic [FLUSH_W-1:0]       flush_reg;
    logic [HALF_W-1:0]        n_reg;
    logic                     m_valid_reg;
    logic [SAMPLE_BITS-1:0]   m_average_reg;
    logic                     m_final_res_reg;

    logic [FLUSH_W-1:0]       flush_inc;
    logic [CNT_W-1:0]         right_cnt;
    logic [CNT_W-1:0]         left_cnt;
    logic [CNT_W-1:0]         need;
    logic                     must_drop;
    logic signed [SUM_W-1:0]  sum_dropped;
    logic [RING_AW-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0]   rd_data;
    logic                     div_start;
    logic                     div_done;
    logic signed [SAMPLE_BITS-1:0] div_quot;
    logic                     out_free;
    logic                     more_burst;

    // The oldest summed sample sits seen entries behind the write slot.
    assign rd_addr     = head_reg - seen_reg[RING_AW-1:0];
    assign sum_dropped = sum_reg - sext_sample(rd_data);
    assign flush_inc   = (flush_reg == '1) ? flush_reg : flush_reg + FLUSH_W'(1);

    assign right_cnt = (HALF_W'(flush_reg) < h_reg) ? CNT_W'(flush_reg) : CNT_W'(h_reg);
    assign left_cnt  = (emit_reg < CNT_W'(h_reg)) ? emit_reg : CNT_W'(h_reg);
    assign need      = right_cnt + left_cnt;
    assign must_drop = (seen_reg > need) && (seen_reg > CNT_W'(1));

    assign div_start  = (state_reg == S_CHECK) && !must_drop;
    assign out_free   = !m_valid_reg || m_ready;
    assign more_burst = (flush_reg > FLUSH_W'(1)) && (int'(n_reg) + 1 < MAX_HALF);

    esma_ring u_ring (
        .aclk    (aclk),
        .wr_en   (state_reg == S_PUSH),
        .wr_addr (head_reg),
        .wr_data (sample_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    esma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (seen_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= CFG_W'(4);
        end else if (cfg_valid) begin
            half_width_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            sum_reg         <= '0;
            seen_reg        <= '0;
            emit_reg        <= '0;
            flush_reg       <= '0;
            n_reg           <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // In S_OUT the output register is refilled whenever it frees up.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        sample_reg <= s_sample;
                        last_reg   <= s_last;
                        h_reg      <= eff_half(half_width_reg);
                        n_reg      <= '0;
                        state_reg  <= (seen_reg == CNT_W'(RING_DEPTH)) ? S_PRE_RD : S_PUSH;
                    end
                end
                S_PRE_RD: begin
                    state_reg <= S_PRE_SUB;
                end
                S_PRE_SUB: begin
                    sum_reg   <= sum_dropped;
                    seen_reg  <= seen_reg - CNT_W'(1);
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    head_reg  <= head_reg + RING_AW'(1);
                    sum_reg   <= sum_reg + sext_sample(sample_reg);
                    seen_reg  <= seen_reg + CNT_W'(1);
                    flush_reg <= flush_inc;
                    if (last_reg || HALF_W'(flush_inc) >= h_reg) begin
                        state_reg <= S_CHECK;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    state_reg <= must_drop ? S_DROP_RD : S_DIV;
                end
                S_DROP_RD: begin
                    state_reg <= S_DROP_SUB;
                end
                S_DROP_SUB: begin
                    sum_reg   <= sum_dropped;
                    seen_reg  <= seen_reg - CNT_W'(1);
                    state_reg <= S_CHECK;
                end
                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_average_reg   <= div_quot;
                        m_final_res_reg <= last_reg && ((flush_reg == FLUSH_W'(1)) ||
                                                        (int'(n_reg) == MAX_HALF - 1));
                        n_reg           <= n_reg + HALF_W'(1);
                        if (!last_reg || more_burst) begin
                            flush_reg <= flush_reg - FLUSH_W'(1);
                            if (emit_reg != CNT_W'(RING_DEPTH)) begin
                                emit_reg <= emit_reg + CNT_W'(1);
                            end
                            state_reg <= last_reg ? S_CHECK : S_IDLE;
                        end else begin
                            // End of stream: start the next one at position zero.
                            sum_reg   <= '0;
                            seen_reg  <= '0;
                            emit_reg  <= '0;
                            flush_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_average   = signed'(m_average_reg);
    assign m_final_res = m_final_res_reg;

endmodule

// ----- rtl/core/esma_ring.sv -----
module esma_ring import esma_pkg::*; (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [RING_AW-1:0]     wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    input  logic [RING_AW-1:0]     rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/esma_div.sv -----
module esma_div import esma_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SUM_W-1:0]       dividend,
    input  logic [CNT_W-1:0]              divisor,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [SUM_W-1:0]  q_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic              neg_reg;

    logic [CNT_W:0]         trial;
    logic                   fits;
    logic [CNT_W:0]         diff;
    logic [SUM_W-1:0]       magnitude;
    logic [SAMPLE_BITS-1:0] q_lo;

    // Restoring division on the magnitude, one quotient bit per cycle; the
    // dividend bits shift out of q_reg as the quotient bits shift in.
    assign trial     = {rem_reg, q_reg[SUM_W-1]};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign diff      = trial - {1'b0, dvs_reg};
    assign magnitude = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= magnitude;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[SUM_W-1];
        end else if (busy_reg) begin
            q_reg   <= {q_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign q_lo     = q_reg[SAMPLE_BITS-1:0];
    assign quotient = neg_reg ? signed'(SAMPLE_BITS'('0) - q_lo) : signed'(q_lo);
    assign done     = done_reg;

endmodule

// ----- rtl/core/esma_checker.sv -----
module esma_checker import esma_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [SAMPLE_BITS-1:0] m_average,
    input logic                   m_final_res
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average) && $stable(m_final_res))
        else $error("stalled result changed");

    // One item is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input still ready right after an item was taken");

    // A result is only produced while an item is being worked on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while the block was idle");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind edge_shrinking_moving_average esma_checker u_esma_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_average   (m_average),
    .m_final_res (m_final_res)
);

// ----- bench/tb_edge_shrinking_moving_average.sv -----
module tb_edge_shrinking_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import esma_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          final_res;
    } avg_item_t;

    logic                          aclk;
    logic                          aresetn     = 1'b0;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [CFG_W-1:0]              cfg_data    = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample    = '0;
    logic                          s_last      = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_average;
    logic                          m_final_res;

    // Predictor state of the centered average.
    logic signed [SAMPLE_BITS-1:0] win_samples [RING_DEPTH];
    logic [RING_AW-1:0]            win_head  = '0;
    logic signed [SUM_W-1:0]       win_sum   = '0;
    logic [CNT_W-1:0]              win_count = '0;
    logic [CNT_W-1:0]              next_pos  = '0;
    logic [FLUSH_W-1:0]            unflushed = '0;
    logic [CFG_W-1:0]              half_reg  = 6'd4;

    avg_item_t pending_averages [$];

    int errors      = 0;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    bit hold_pending = 1'b0;

    edge_shrinking_moving_average DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_average   (m_average),
        .m_final_res (m_final_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int active_half();
        if (half_reg == '0) begin
            return 1;
        end
        if (int'(half_reg) > MAX_HALF) begin
            return MAX_HALF;
        end
        return int'(half_reg);
    endfunction

    function automatic void retire_oldest();
        logic [RING_AW-1:0] idx;
        idx = win_head - win_count[RING_AW-1:0];
        win_sum = win_sum - win_samples[idx];
        win_count = win_count - 1'b1;
    endfunction

    function automatic void emit_average(input int h, input logic fin);
        int right;
        int left;
        int need;
        int q;
        avg_item_t item;
        right = (int'(unflushed) < h) ? int'(unflushed) : h;
        left  = (int'(next_pos) < h) ? int'(next_pos) : h;
        need  = right + left;
        // The window shrinks toward the right edge as the flush drains it.
        while (int'(win_count) > need && win_count > 1) begin
            retire_oldest();
        end
        q = int'(win_sum) / int'(win_count);
        item.average   = q[SAMPLE_BITS-1:0];
        item.final_res = fin;
        pending_averages.push_back(item);
        unflushed = unflushed - 1'b1;
        if (next_pos < RING_DEPTH) begin
            next_pos = next_pos + 1'b1;
        end
    endfunction

    function automatic void push_and_average(input logic signed [SAMPLE_BITS-1:0] smp,
                                             input logic lst);
        int h;
        int n;
        h = active_half();
        if (win_count >= RING_DEPTH) begin
            retire_oldest();
        end
        win_samples[win_head] = smp;
        win_head  = win_head + 1'b1;
        win_sum   = win_sum + smp;
        win_count = win_count + 1'b1;
        if (unflushed < 63) begin
            unflushed = unflushed + 1'b1;
        end
        if (!lst) begin
            if (int'(unflushed) >= h) begin
                emit_average(h, 1'b0);
            end
        end else begin
            n = 0;
            while (unflushed > 0 && n < MAX_HALF) begin
                emit_average(h, (unflushed == 1) || (n == MAX_HALF - 1));
                n++;
            end
            win_sum   = '0;
            win_count = '0;
            next_pos  = '0;
            unflushed = '0;
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= lst;
        do @(posedge aclk); while (!s_ready);
        push_and_average(smp, lst);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_averages.size() != 0) begin
            @(posedge aclk);
        end
        // A pushed item that causes no average may still be in progress.
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_half_width(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        half_reg = value;
    endtask

    task automatic test_edge_values();
        // Reset half width of four, full-scale samples of both signs.
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        // A stream of one sample, then one shorter than the half width.
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b1);
    endtask

    task automatic test_width_limits();
        write_half_width(6'd0);
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd3, 1'b1);
        write_half_width(6'd63);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd4, 1'b1);
        write_half_width(6'd1);
        send_sample(16'sh7FFF, 1'b1);
    endtask

    task automatic test_width_change_midstream();
        write_half_width(6'd5);
        repeat (5) send_sample(16'($urandom), 1'b0);
        write_half_width(6'd1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        write_half_width(6'd3);
        repeat (3) send_sample(16'($urandom), 1'b0);
        write_half_width(6'd40);
        send_sample(-16'sd9, 1'b1);
    endtask

    task automatic test_full_ring_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        write_half_width(6'd32);
        // Result side is held off while items keep coming, so the input stalls.
        hold_pending = 1'b1;
        for (int i = 0; i < 66; i++) begin
            send_sample(16'($urandom), i == 65);
        end
    endtask

    task automatic test_random_streams(input int idle, input int stall, input int item_goal);
        int sent;
        int stream_left;
        logic signed [SAMPLE_BITS-1:0] smp;
        idle_pct  = idle;
        stall_pct = stall;
        if ($urandom_range(3) == 0) begin
            write_half_width(CFG_W'($urandom_range(0, 63)));
        end else begin
            write_half_width(CFG_W'($urandom_range(1, 8)));
        end
        sent = 0;
        stream_left = 0;
        while (sent < item_goal) begin
            if (stream_left == 0) begin
                stream_left = $urandom_range(1, 3 * active_half() + 2);
            end
            case ($urandom_range(7))
                0: smp = 16'sh7FFF;
                1: smp = 16'sh8000;
                default: smp = 16'($urandom);
            endcase
            // A stream cut short at the end of a phase carries into the next setting.
            send_sample(smp, stream_left == 1);
            stream_left--;
            sent++;
        end
    endtask

    always @(posedge aclk) begin : drive_result_ready
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : check_averages
        avg_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_averages.size() == 0) begin
                $display("%0t: unexpected item, expected none, got average %0d final %0b",
                         $time, m_average, m_final_res);
                errors++;
            end else begin
                want = pending_averages.pop_front();
                if (m_average !== want.average) begin
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, want.average, m_average);
                    errors++;
                end
                if (m_final_res !== want.final_res) begin
                    $display("%0t: final_res mismatch, expected %0b, got %0b",
                             $time, want.final_res, m_final_res);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_values();
        test_width_limits();
        test_width_change_midstream();
        test_full_ring_backpressure();
        test_random_streams(0, 0, 5);
        test_random_streams(77, 0, 5);
        test_random_streams(0, 77, 5);
        test_random_streams(26, 26, 5);
        wait_drained();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
